/* src/sct_pkg.sv */
`timescale 1ns / 1ps

package sct_pkg;

    // Slots of one queue entry, in the order in which their tokens leave the block.
    localparam int NSLOT       = 8;
    localparam int SLOT_IDX_W  = $clog2(NSLOT);
    localparam int SLOT_WEND   = 0;  // word end caused by a split left by an operator, or at end of input
    localparam int SLOT_POPEN  = 1;
    localparam int SLOT_PCLOSE = 2;
    localparam int SLOT_RIN    = 3;
    localparam int SLOT_ROUT   = 4;
    localparam int SLOT_AMP    = 5;
    localparam int SLOT_PIPE   = 6;
    localparam int SLOT_TAIL   = 7;  // character, word end or end token

    localparam int SCT_QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        TK_CHAR   = 4'd0,
        TK_WEND   = 4'd1,
        TK_POPEN  = 4'd2,
        TK_PCLOSE = 4'd3,
        TK_RIN    = 4'd4,
        TK_RINH   = 4'd5,
        TK_ROUT   = 4'd6,
        TK_APPEND = 4'd7,
        TK_ROUTH  = 4'd8,
        TK_AMP    = 4'd9,
        TK_AMP2   = 4'd10,
        TK_PIPE   = 4'd11,
        TK_PIPE2  = 4'd12,
        TK_END    = 4'd13
    } tok_kind_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NEL    = 8'h85;
    localparam logic [7:0] CH_NBSP   = 8'hA0;

    // Operator runs saturate here; a quote run at this count makes the next quote literal.
    localparam logic [1:0] RUN_MAX = 2'd2;
    localparam logic [1:0] RUN_ONE = 2'd1;

    typedef struct packed {
        logic [NSLOT-1:0]       valid;
        logic [NSLOT-1:0][3:0]  kind;
        logic [7:0]             ch;
    } sct_entry_t;

    localparam int ENTRY_W = $bits(sct_entry_t);

endpackage

/* src/shell_command_tokenizer.sv */
`timescale 1ns / 1ps

// Channel  Signals                              Contents
// -------  -----------------------------------  ----------------------------------------
// s_       s_tvalid s_tready s_tdata s_tuser     tdata: ch; tuser: req_type
// m_       m_tvalid m_tready m_tdata m_tuser     tdata: word_char; tuser: token_kind;
//          m_tlast                               tlast: last token of the input word
//
// An input word is taken whenever the token queue has room, so words can arrive back to
// back. Each word yields zero to seven tokens; the output stage sends one token per cycle
// while m_tready allows, and a silent word produces no output. The first token passes
// through the queue and then the output register before it is valid.
// Reset clears the tokenizer state, the queue and the output stage; nothing is swept.
// A stalled output fills the queue and then drops s_tready; the input side never stalls
// the output.

module shell_command_tokenizer
    import sct_pkg::*;
#(
    parameter int QUEUE_DEPTH = SCT_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tuser,   // [0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] word_char
    output logic [3:0] m_tuser,   // [3:0] token_kind
    output logic       m_tlast
);

    // The front end classifies each character against the tokenizer state and turns it
    // into at most one queue entry: a set of token slots in their fixed output order.
    logic               q_full;
    logic               q_push;
    sct_entry_t         q_entry;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_head_bits;
    sct_entry_t         q_head;

    sct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // The queue lets the front end run ahead while a burst of tokens drains.
    sct_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head_bits)
    );

    assign q_head = sct_entry_t'(q_head_bits);

    // The back end walks the slots of the head entry, one token per cycle while m_tready allows.
    sct_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // The front end must never write into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("token queue written while full");

    // Every queued entry carries at least one token; an empty one would send a spurious token.
    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_entry.valid != '0))
        else $error("empty entry pushed into the token queue");

    // The end token is always the final token of its input word.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == TK_END)) |-> m_tlast)
        else $error("end token sent without tlast");

    // Only word characters carry data.
    a_char_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != TK_CHAR)) |-> (m_tdata == 8'h00))
        else $error("non-character token with nonzero data");
`endif

endmodule

/* src/sct_front.sv */
`timescale 1ns / 1ps

module sct_front
    import sct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       q_full,
    output logic       q_push,
    output sct_entry_t q_entry
);

    typedef struct packed {
        logic       in_quote;
        logic       escape_armed;
        logic [1:0] quote_run;
        logic       open_pend;
        logic       close_pend;
        logic [1:0] amp_run;
        logic [1:0] pipe_run;
        logic [1:0] less_run;
        logic [1:0] greater_run;
        logic       split_pend;
        logic       word_open;
    } sct_state_t;

    sct_state_t st_reg;
    sct_state_t st_next;
    logic       accept;

    function automatic logic [1:0] bump(input logic [1:0] v);
        return (v >= RUN_MAX) ? RUN_MAX : v + 2'd1;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && (q_entry.valid != '0);

    always_comb
    begin
        logic       c_quote;
        logic       c_op;
        logic       c_blank;
        logic       iq;
        logic       op_now;
        logic       any_pend;
        logic       amp_left;
        tok_kind_t  rin_k;
        tok_kind_t  rout_k;
        tok_kind_t  amp_k;
        tok_kind_t  pipe_k;

        st_next = st_reg;
        q_entry = '0;

        c_quote = (s_tdata == CH_QUOTE);
        c_op    = (s_tdata == CH_AMP) || (s_tdata == CH_PIPE) || (s_tdata == CH_LESS)
               || (s_tdata == CH_GREAT) || (s_tdata == CH_LPAREN) || (s_tdata == CH_RPAREN);
        c_blank = (s_tdata == CH_SPACE) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CR))
               || (s_tdata == CH_NEL) || (s_tdata == CH_NBSP);

        iq       = st_reg.in_quote ^ (st_reg.quote_run == RUN_ONE);
        op_now   = c_op && !iq && !st_reg.escape_armed;
        any_pend = st_reg.open_pend || st_reg.close_pend || (st_reg.less_run != '0)
                || (st_reg.greater_run != '0) || (st_reg.amp_run != '0)
                || (st_reg.pipe_run != '0);

        // Redirections take a pending ampersand with them; the input redirection wins it.
        rin_k    = (st_reg.amp_run != '0) ? TK_RINH : TK_RIN;
        amp_left = (st_reg.less_run != '0) ? 1'b0 : (st_reg.amp_run != '0);
        if (amp_left)
            rout_k = TK_ROUTH;
        else if (st_reg.greater_run == RUN_ONE)
            rout_k = TK_ROUT;
        else
            rout_k = TK_APPEND;
        amp_k  = (st_reg.amp_run == RUN_ONE) ? TK_AMP : TK_AMP2;
        pipe_k = (st_reg.pipe_run == RUN_ONE) ? TK_PIPE : TK_PIPE2;

        if (s_tuser)
        begin
            // End of input: close the word, emit a pending close paren, then end.
            if (st_reg.word_open)
            begin
                q_entry.valid[SLOT_WEND] = 1'b1;
                q_entry.kind[SLOT_WEND]  = TK_WEND;
            end
            if (st_reg.close_pend)
            begin
                q_entry.valid[SLOT_PCLOSE] = 1'b1;
                q_entry.kind[SLOT_PCLOSE]  = TK_PCLOSE;
            end
            q_entry.valid[SLOT_TAIL] = 1'b1;
            q_entry.kind[SLOT_TAIL]  = TK_END;
            st_next = '0;
        end
        else
        begin
            if (st_reg.split_pend)
            begin
                st_next.split_pend = 1'b0;
                if (st_reg.word_open)
                begin
                    q_entry.valid[SLOT_WEND] = 1'b1;
                    q_entry.kind[SLOT_WEND]  = TK_WEND;
                    st_next.word_open        = 1'b0;
                end
            end

            if (c_quote)
            begin
                if (st_reg.quote_run >= RUN_MAX)
                begin
                    st_next.quote_run        = '0;
                    q_entry.valid[SLOT_TAIL] = 1'b1;
                    q_entry.kind[SLOT_TAIL]  = TK_CHAR;
                    q_entry.ch               = s_tdata;
                    st_next.word_open        = 1'b1;
                end
                else
                begin
                    st_next.quote_run = st_reg.quote_run + 2'd1;
                end
            end
            else if (c_op && !st_reg.in_quote && !st_reg.escape_armed)
            begin
                st_next.split_pend = 1'b1;
            end
            else
            begin
                st_next.in_quote  = iq;
                st_next.quote_run = '0;
                if (op_now && any_pend)
                begin
                    // The quote run just closed, so this character is an operator
                    // now: only the first pending token leaves, the rest stay.
                    priority if (st_reg.open_pend)
                    begin
                        q_entry.valid[SLOT_POPEN] = 1'b1;
                        q_entry.kind[SLOT_POPEN]  = TK_POPEN;
                        st_next.open_pend         = 1'b0;
                    end
                    else if (st_reg.close_pend)
                    begin
                        q_entry.valid[SLOT_PCLOSE] = 1'b1;
                        q_entry.kind[SLOT_PCLOSE]  = TK_PCLOSE;
                        st_next.close_pend         = 1'b0;
                    end
                    else if (st_reg.less_run != '0)
                    begin
                        q_entry.valid[SLOT_RIN] = 1'b1;
                        q_entry.kind[SLOT_RIN]  = rin_k;
                        st_next.less_run        = '0;
                        st_next.amp_run         = '0;
                    end
                    else if (st_reg.greater_run != '0)
                    begin
                        q_entry.valid[SLOT_ROUT] = 1'b1;
                        q_entry.kind[SLOT_ROUT]  = rout_k;
                        st_next.greater_run      = '0;
                        st_next.amp_run          = '0;
                    end
                    else if (st_reg.amp_run != '0)
                    begin
                        q_entry.valid[SLOT_AMP] = 1'b1;
                        q_entry.kind[SLOT_AMP]  = amp_k;
                        st_next.amp_run         = '0;
                    end
                    else
                    begin
                        q_entry.valid[SLOT_PIPE] = 1'b1;
                        q_entry.kind[SLOT_PIPE]  = pipe_k;
                        st_next.pipe_run         = '0;
                    end
                    st_next.split_pend = 1'b1;
                end
                else
                begin
                    // Drain every pending operator, then handle the character.
                    q_entry.valid[SLOT_POPEN]  = st_reg.open_pend;
                    q_entry.kind[SLOT_POPEN]   = TK_POPEN;
                    q_entry.valid[SLOT_PCLOSE] = st_reg.close_pend;
                    q_entry.kind[SLOT_PCLOSE]  = TK_PCLOSE;
                    q_entry.valid[SLOT_RIN]    = (st_reg.less_run != '0);
                    q_entry.kind[SLOT_RIN]     = rin_k;
                    q_entry.valid[SLOT_ROUT]   = (st_reg.greater_run != '0);
                    q_entry.kind[SLOT_ROUT]    = rout_k;
                    q_entry.valid[SLOT_AMP]    = (st_reg.greater_run == '0) && amp_left;
                    q_entry.kind[SLOT_AMP]     = amp_k;
                    q_entry.valid[SLOT_PIPE]   = (st_reg.pipe_run != '0);
                    q_entry.kind[SLOT_PIPE]    = pipe_k;
                    st_next.open_pend   = 1'b0;
                    st_next.close_pend  = 1'b0;
                    st_next.less_run    = '0;
                    st_next.greater_run = '0;
                    st_next.amp_run     = '0;
                    st_next.pipe_run    = '0;

                    if (!iq && c_blank)
                    begin
                        st_next.escape_armed = 1'b0;
                        if (st_next.word_open)
                        begin
                            q_entry.valid[SLOT_TAIL] = 1'b1;
                            q_entry.kind[SLOT_TAIL]  = TK_WEND;
                            st_next.word_open        = 1'b0;
                        end
                    end
                    else if (!iq && !st_reg.escape_armed && (s_tdata == CH_CARET))
                    begin
                        st_next.escape_armed = 1'b1;
                    end
                    else
                    begin
                        q_entry.valid[SLOT_TAIL] = 1'b1;
                        q_entry.kind[SLOT_TAIL]  = TK_CHAR;
                        q_entry.ch               = s_tdata;
                        st_next.word_open        = 1'b1;
                        st_next.escape_armed     = 1'b0;
                    end
                end
            end

            // An operator character, taken now or after a closed quote run, is counted.
            if (st_next.split_pend && !st_reg.split_pend || (st_next.split_pend && c_op))
            begin
                unique case (s_tdata)
                    CH_AMP:    st_next.amp_run     = bump(st_next.amp_run);
                    CH_PIPE:   st_next.pipe_run    = bump(st_next.pipe_run);
                    CH_LESS:   st_next.less_run    = bump(st_next.less_run);
                    CH_GREAT:  st_next.greater_run = bump(st_next.greater_run);
                    CH_LPAREN: st_next.open_pend   = 1'b1;
                    CH_RPAREN: st_next.close_pend  = 1'b1;
                    default:   st_next.split_pend  = st_next.split_pend;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (accept)
            st_reg <= st_next;
    end

endmodule

/* src/sct_queue.sv */
`timescale 1ns / 1ps

module sct_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* src/sct_back.sv */
`timescale 1ns / 1ps

module sct_back
    import sct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  sct_entry_t q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [3:0] m_tuser,
    output logic       m_tlast
);

    logic [NSLOT-1:0]      sent_reg;
    logic [NSLOT-1:0]      sent_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [3:0]            out_kind_reg;
    logic [7:0]            out_char_reg;
    logic                  out_last_reg;
    logic [NSLOT-1:0]      remaining;
    logic [NSLOT-1:0]      pick_oh;
    logic [SLOT_IDX_W-1:0] pick_idx;
    logic                  pick_last;
    logic                  advance;
    logic                  take;
    logic [3:0]            pick_kind;

    // The lowest slot not yet sent is the next token of the head entry.
    always_comb
    begin
        logic found;
        remaining = q_head.valid & ~sent_reg;
        found     = 1'b0;
        pick_idx  = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (!found && remaining[i])
            begin
                pick_idx = SLOT_IDX_W'(i);
                found    = 1'b1;
            end
        end
        pick_oh           = '0;
        pick_oh[pick_idx] = found;
        pick_last         = ((remaining & ~pick_oh) == '0);
    end

    assign pick_kind = q_head.kind[pick_idx];
    assign advance   = !out_valid_reg || m_tready;
    assign take      = advance && q_valid;
    assign q_pop     = take && pick_last;

    always_comb
    begin
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = q_valid;
        if (take)
            sent_next = pick_last ? '0 : (sent_reg | pick_oh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_kind_reg <= pick_kind;
            out_char_reg <= (pick_kind == TK_CHAR) ? q_head.ch : 8'h00;
            out_last_reg <= pick_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule
